@@ sv/spatial_cell_list_binning_defines.svh @@
// assertion macros for the cell list binning block
// no dependencies; included by files that carry assertions
`ifndef SPATIAL_CELL_LIST_BINNING_DEFINES_SVH
`define SPATIAL_CELL_LIST_BINNING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scb check failed");
`define SCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scb check failed");
`else
`define SCB_ASSERT_SAME(lbl, ante, cons)
`define SCB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/scb_pkg.sv @@
// shared types and constants for the cell list binning block
// no dependencies
`timescale 1ns / 1ps
package scb_pkg;
    localparam int MAX_AGENTS = 1024;
    localparam int MAX_CELLS  = 1024;
    localparam int LINK_DEPTH = MAX_AGENTS + 2 * MAX_CELLS;
    localparam int HEAD_BASE  = MAX_AGENTS;
    localparam int TAIL_BASE  = MAX_AGENTS + MAX_CELLS;
    localparam int LINK_W     = 12;
    localparam int AGENT_W    = 10;
    localparam int CELL_W     = 10;
    localparam int POS_W      = 24;
    localparam int DIM_W      = 6;
    localparam int BIN_W      = 5;
    localparam int QUO_W      = 6;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_UPDATE = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [1:0] CFG_ACROSS = 2'd0;
    localparam logic [1:0] CFG_DOWN   = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [AGENT_W-1:0] agent_id;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [LINK_W-1:0] link_index;
    } t_item;

    typedef struct packed {
        logic              status;
        logic [LINK_W-1:0] link_value;
        logic [BIN_W-1:0]  cell_col;
        logic [BIN_W-1:0]  cell_row;
        logic              last;
    } t_result;

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        d = r;
        if (r == '0) d = DIM_W'(1);
        else if (r > DIM_W'(32)) d = DIM_W'(32);
        return d;
    endfunction
endpackage

@@ sv/spatial_cell_list_binning.sv @@
// top level of the cell list binning block: sequencer and link memories
// depends on scb_pkg, scb_bin_div and spatial_cell_list_binning_defines.svh
`timescale 1ns / 1ps
`include "spatial_cell_list_binning_defines.svh"
// Bins agents into a grid of cells kept as doubly linked lists. After reset the
// block runs a clearing pass over the link and agent memories and holds o_busy
// high; configuration writes are taken during it. An item is taken when i_start
// is high and o_busy low. Every item first passes the two bin dividers (one
// quotient bit a cycle), then the sequencer: read, unknown and ignored items end
// in S_DECIDE, add goes through S_APP_W1 and S_APP_W2, delete through S_UNLINK,
// update ends in S_DECIDE or, if its cell changes, goes through S_UNLINK, S_APP_RD,
// S_APP_W1 and S_APP_W2, and a query gives its 1, 3 or 5 results on consecutive
// cycles. Results come one beat per cycle with o_strobe high and cannot be held off.
module spatial_cell_list_binning (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  scb_pkg::t_item             i_item,
    output logic                       o_strobe,
    output scb_pkg::t_result           o_result,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [scb_pkg::POS_W-1:0]  i_cfg_data
);
    localparam int LW = scb_pkg::LINK_W;
    localparam int AW = scb_pkg::AGENT_W;
    localparam int CW = scb_pkg::CELL_W;
    localparam int BW = scb_pkg::BIN_W;
    localparam int DW = scb_pkg::DIM_W;
    localparam logic [2:0] Q_UP    = 3'd1;
    localparam logic [2:0] Q_DOWN  = 3'd2;
    localparam logic [2:0] Q_RIGHT = 3'd3;
    localparam logic [2:0] Q_LEFT  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_DECIDE, S_UNLINK, S_APP_RD, S_APP_W1, S_APP_W2, S_QUERY
    } t_state;

    t_state                   r_state;
    logic [LW-1:0]            r_clr;
    scb_pkg::t_item           r_item;
    logic [BW-1:0]            r_col, r_row;
    logic [2:0]               r_qk;
    logic                     r_strobe;
    scb_pkg::t_result         r_res;
    logic [DW-1:0]            r_across, r_down;
    logic [scb_pkg::POS_W-1:0] r_cw, r_ch;

    logic [LW-1:0] next_mem  [scb_pkg::LINK_DEPTH];
    logic [LW-1:0] prior_mem [scb_pkg::LINK_DEPTH];
    logic [AW:0]   agent_mem [scb_pkg::MAX_AGENTS];
    logic [LW-1:0] r_next_q, r_prior_q;
    logic [AW:0]   r_agent_q;

    logic          next_we, next_re, prior_we, prior_re, agent_we, agent_re;
    logic [LW-1:0] next_wa, next_ra, next_wd, prior_wa, prior_ra, prior_wd;
    logic [AW-1:0] agent_wa, agent_ra;
    logic [AW:0]   agent_wd;

    logic                      accept, div_go, div_done, div_done_y;
    logic [BW-1:0]             bin_x, bin_y;
    logic [DW-1:0]             nx, ny;
    logic [scb_pkg::POS_W-1:0] cw_eff, ch_eff;
    logic                      wide_x, wide_y;
    logic [CW:0]               cell_sum;
    logic [CW-1:0]             cell_idx;
    logic [LW-1:0]             tail, id_link;
    logic                      exists, changed;
    logic [CW-1:0]             new_code, old_code;
    logic [BW-1:0]             q_col, q_row;
    logic                      q_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_across <= DW'(1);
            r_down   <= DW'(1);
            r_cw     <= scb_pkg::POS_W'(256);
            r_ch     <= scb_pkg::POS_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scb_pkg::CFG_ACROSS: r_across <= i_cfg_data[DW-1:0];
                scb_pkg::CFG_DOWN:   r_down   <= i_cfg_data[DW-1:0];
                scb_pkg::CFG_WIDTH:  r_cw     <= i_cfg_data;
                scb_pkg::CFG_HEIGHT: r_ch     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nx     = scb_pkg::dim_clamp(r_across);
    assign ny     = scb_pkg::dim_clamp(r_down);
    assign cw_eff = (r_cw == '0) ? scb_pkg::POS_W'(1) : r_cw;
    assign ch_eff = (r_ch == '0) ? scb_pkg::POS_W'(1) : r_ch;
    assign wide_x = nx > DW'(3);
    assign wide_y = ny > DW'(3);

    assign accept = i_start && (r_state == S_IDLE);
    assign div_go = accept;

    scb_bin_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go), .i_pos(i_item.pos_x),
        .i_size(cw_eff), .i_dim(nx), .o_done(div_done), .o_bin(bin_x)
    );
    scb_bin_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go), .i_pos(i_item.pos_y),
        .i_size(ch_eff), .i_dim(ny), .o_done(div_done_y), .o_bin(bin_y)
    );

    // row * cols + col never passes the cell count, the mask keeps the wrap
    assign cell_sum = (CW + 1)'(r_row) * (CW + 1)'(nx) + (CW + 1)'(r_col);
    assign cell_idx = cell_sum[CW-1:0];
    assign tail     = LW'(scb_pkg::TAIL_BASE) + LW'(cell_idx);
    assign id_link  = LW'(r_item.agent_id);
    assign exists   = r_agent_q[AW];
    assign old_code = r_agent_q[CW-1:0];
    assign new_code = {r_row, r_col};
    assign changed  = old_code != new_code;

    // neighbour cell for the current query step
    always_comb begin
        q_col = r_col;
        q_row = r_row;
        case (r_qk)
            Q_UP:    q_row = ({1'b0, r_row} == ny - DW'(1)) ? '0 : r_row + BW'(1);
            Q_DOWN:  q_row = (r_row == '0) ? BW'(ny - DW'(1)) : r_row - BW'(1);
            Q_RIGHT: q_col = ({1'b0, r_col} == nx - DW'(1)) ? '0 : r_col + BW'(1);
            Q_LEFT:  q_col = (r_col == '0) ? BW'(nx - DW'(1)) : r_col - BW'(1);
            default: ;
        endcase
        q_last = (r_qk == Q_LEFT) || (r_qk == Q_DOWN && !wide_x);
    end

    // memory port control
    always_comb begin
        next_we  = 1'b0; next_wa  = '0; next_wd  = '0;
        next_re  = 1'b0; next_ra  = '0;
        prior_we = 1'b0; prior_wa = '0; prior_wd = '0;
        prior_re = 1'b0; prior_ra = '0;
        agent_we = 1'b0; agent_wa = '0; agent_wd = '0;
        agent_re = 1'b0; agent_ra = '0;
        case (r_state)
            S_CLEAR: begin
                next_we  = 1'b1;
                next_wa  = r_clr;
                prior_we = 1'b1;
                prior_wa = r_clr;
                if (r_clr >= LW'(scb_pkg::HEAD_BASE) && r_clr < LW'(scb_pkg::TAIL_BASE))
                    next_wd = r_clr + LW'(scb_pkg::MAX_CELLS);
                if (r_clr >= LW'(scb_pkg::TAIL_BASE))
                    prior_wd = r_clr - LW'(scb_pkg::MAX_CELLS);
                agent_we = 1'b1;
                agent_wa = r_clr[AW-1:0];
            end
            S_IDLE: begin
                agent_re = accept;
                agent_ra = i_item.agent_id;
                next_re  = accept && (i_item.link_index < LW'(scb_pkg::LINK_DEPTH));
                next_ra  = i_item.link_index;
            end
            S_DECIDE: begin
                case (r_item.opcode)
                    scb_pkg::OP_ADD: if (!exists) begin
                        agent_we = 1'b1;
                        agent_wa = r_item.agent_id;
                        agent_wd = {1'b1, new_code};
                        prior_re = 1'b1;
                        prior_ra = tail;
                    end
                    scb_pkg::OP_UPDATE: if (exists && changed) begin
                        agent_we = 1'b1;
                        agent_wa = r_item.agent_id;
                        agent_wd = {1'b1, new_code};
                        prior_re = 1'b1;
                        prior_ra = id_link;
                        next_re  = 1'b1;
                        next_ra  = id_link;
                    end
                    scb_pkg::OP_DELETE: if (exists) begin
                        agent_we = 1'b1;
                        agent_wa = r_item.agent_id;
                        agent_wd = {1'b0, old_code};
                        prior_re = 1'b1;
                        prior_ra = id_link;
                        next_re  = 1'b1;
                        next_ra  = id_link;
                    end
                    default: ;
                endcase
            end
            S_UNLINK: begin
                next_we  = 1'b1;
                next_wa  = r_prior_q;
                next_wd  = r_next_q;
                prior_we = 1'b1;
                prior_wa = r_next_q;
                prior_wd = r_prior_q;
            end
            S_APP_RD: begin
                prior_re = 1'b1;
                prior_ra = tail;
            end
            S_APP_W1: begin
                next_we  = 1'b1;
                next_wa  = r_prior_q;
                next_wd  = id_link;
                prior_we = 1'b1;
                prior_wa = id_link;
                prior_wd = r_prior_q;
            end
            S_APP_W2: begin
                next_we  = 1'b1;
                next_wa  = id_link;
                next_wd  = tail;
                prior_we = 1'b1;
                prior_wa = tail;
                prior_wd = id_link;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        if (next_re) r_next_q <= next_mem[next_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prior_we) prior_mem[prior_wa] <= prior_wd;
        if (prior_re) r_prior_q <= prior_mem[prior_ra];
    end

    always_ff @(posedge i_clk) begin
        if (agent_we) agent_mem[agent_wa] <= agent_wd;
        if (agent_re) r_agent_q <= agent_mem[agent_ra];
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
            r_res    <= '0;
            r_qk     <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + LW'(1);
                    if (r_clr == LW'(scb_pkg::LINK_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (accept) begin
                    r_item  <= i_item;
                    r_state <= S_DIV;
                end
                S_DIV: if (div_done) begin
                    r_col   <= bin_x;
                    r_row   <= bin_y;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                    r_res    <= '{status: 1'b1, link_value: '0, cell_col: '0,
                                  cell_row: '0, last: 1'b1};
                    case (r_item.opcode)
                        scb_pkg::OP_ADD: if (!exists) begin
                            r_strobe <= 1'b0;
                            r_state  <= S_APP_W1;
                        end
                        scb_pkg::OP_UPDATE: if (exists) begin
                            if (changed) begin
                                r_strobe <= 1'b0;
                                r_state  <= S_UNLINK;
                            end else begin
                                r_res <= '{status: 1'b0, link_value: '0, cell_col: r_col,
                                          cell_row: r_row, last: 1'b1};
                            end
                        end
                        scb_pkg::OP_DELETE: if (exists) begin
                            r_strobe <= 1'b0;
                            r_state  <= S_UNLINK;
                        end
                        scb_pkg::OP_READ:
                            if (r_item.link_index < LW'(scb_pkg::LINK_DEPTH)) begin
                                r_res <= '{status: 1'b0, link_value: r_next_q,
                                          cell_col: '0, cell_row: '0, last: 1'b1};
                            end
                        scb_pkg::OP_QUERY: begin
                            r_res <= '{status: 1'b0, link_value: '0, cell_col: r_col,
                                      cell_row: r_row, last: !wide_x && !wide_y};
                            if (wide_x || wide_y) begin
                                r_qk    <= wide_y ? Q_UP : Q_RIGHT;
                                r_state <= S_QUERY;
                            end
                        end
                        default: ;
                    endcase
                end
                S_UNLINK: begin
                    if (r_item.opcode == scb_pkg::OP_DELETE) begin
                        r_strobe <= 1'b1;
                        r_res    <= '{status: 1'b0, link_value: '0,
                                     cell_col: old_code[BW-1:0],
                                     cell_row: old_code[CW-1:BW], last: 1'b1};
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_APP_RD;
                    end
                end
                S_APP_RD: r_state <= S_APP_W1;
                S_APP_W1: r_state <= S_APP_W2;
                S_APP_W2: begin
                    r_strobe <= 1'b1;
                    r_res    <= '{status: 1'b0, link_value: '0, cell_col: r_col,
                                 cell_row: r_row, last: 1'b1};
                    r_state  <= S_IDLE;
                end
                S_QUERY: begin
                    r_strobe <= 1'b1;
                    r_res    <= '{status: 1'b0, link_value: '0, cell_col: q_col,
                                 cell_row: q_row, last: q_last};
                    r_qk     <= r_qk + 3'd1;
                    if (q_last) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `SCB_ASSERT_SAME(a_div_pair, div_done, div_done_y)
    `SCB_ASSERT_NEXT(a_start_taken, accept, r_state == S_DIV)
    `SCB_ASSERT_SAME(a_ignored_clean, r_strobe && r_res.status,
        r_res.link_value == '0 && r_res.cell_col == '0 && r_res.cell_row == '0 && r_res.last)
    `SCB_ASSERT_SAME(a_clear_quiet, r_state == S_CLEAR, !r_strobe && o_busy)
endmodule

@@ sv/scb_bin_div.sv @@
// restoring divider that turns a position into a clamped grid bin
// depends on scb_pkg
`timescale 1ns / 1ps
module scb_bin_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [scb_pkg::POS_W-1:0] i_pos,
    input  logic [scb_pkg::POS_W-1:0] i_size,
    input  logic [scb_pkg::DIM_W-1:0] i_dim,
    output logic                      o_done,
    output logic [scb_pkg::BIN_W-1:0] o_bin
);
    localparam int DIV_W = scb_pkg::POS_W + scb_pkg::QUO_W;

    logic                      r_busy;
    logic [2:0]                r_step;
    logic                      r_done;
    logic [scb_pkg::POS_W-1:0] r_rem;
    logic [DIV_W-1:0]          r_div;
    logic [scb_pkg::QUO_W-1:0] r_quo;
    logic                      r_ovf;
    logic [scb_pkg::DIM_W-1:0] r_dim;
    logic                      ge;

    assign ge = {{scb_pkg::QUO_W{1'b0}}, r_rem} >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'(scb_pkg::QUO_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // first step only checks for a quotient past six bits
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_pos;
            r_div <= {i_size, {scb_pkg::QUO_W{1'b0}}};
            r_quo <= '0;
            r_ovf <= 1'b0;
            r_dim <= i_dim;
        end else if (r_busy) begin
            r_div <= r_div >> 1;
            if (r_step == 3'd0) begin
                r_ovf <= ge;
            end else begin
                r_quo <= {r_quo[scb_pkg::QUO_W-2:0], ge};
                if (ge) r_rem <= r_rem - r_div[scb_pkg::POS_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_ovf || r_quo >= r_dim) o_bin = scb_pkg::BIN_W'(r_dim - 6'd1);
        else o_bin = r_quo[scb_pkg::BIN_W-1:0];
    end
    assign o_done = r_done;
endmodule

@@ verif/spatial_cell_list_binning_tb.sv @@
// self-checking testbench for spatial_cell_list_binning: random and directed items, scoreboard
// depends on scb_pkg and the spatial_cell_list_binning rtl
`timescale 1ns / 1ps
module spatial_cell_list_binning_tb;
    localparam logic [2:0] OP_FIRST_SPARE = 3'd5;
    localparam logic [2:0] OP_LAST_SPARE  = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 24;
    localparam int LW = scb_pkg::LINK_W;
    localparam int PW = scb_pkg::POS_W;
    localparam int DW = scb_pkg::DIM_W;
    localparam int CW = scb_pkg::CELL_W;
    localparam int BW = scb_pkg::BIN_W;

    logic i_clk, i_rst_n, i_start, o_busy, o_strobe, i_cfg_we;
    scb_pkg::t_item i_item;
    scb_pkg::t_result o_result;
    logic [1:0] i_cfg_index;
    logic [PW-1:0] i_cfg_data;

    spatial_cell_list_binning uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the block state
    logic [LW-1:0] nxt_link [scb_pkg::LINK_DEPTH];
    logic [LW-1:0] prv_link [scb_pkg::LINK_DEPTH];
    logic [CW-1:0] agent_cell [scb_pkg::MAX_AGENTS];
    logic          agent_live [scb_pkg::MAX_AGENTS];
    logic [DW-1:0] grid_across, grid_down;
    logic [PW-1:0] size_w, size_h;

    scb_pkg::t_item   pending_items[$];
    scb_pkg::t_result due_results[$];
    int      mismatches = 0;
    int      cycles = 0;
    logic    took = 1'b0;
    int      gap_left = 0;
    int      burst_left = 4;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void add_due(input scb_pkg::t_result r);
        due_results = {due_results, r};
    endfunction

    function automatic void queue_item(input scb_pkg::t_item it);
        pending_items = {pending_items, it};
    endfunction

    function automatic int unsigned grid_span(input logic [DW-1:0] r);
        if (r == 0) return 1;
        if (r > 32) return 32;
        return r;
    endfunction

    function automatic int unsigned cell_bin(input logic [PW-1:0] p,
                                             input logic [PW-1:0] s, input int unsigned n);
        int unsigned q;
        q = p / ((s == 0) ? 1 : s);
        return (q >= n) ? n - 1 : q;
    endfunction

    function automatic void link_in(input int unsigned id, input int unsigned col,
                                    input int unsigned row);
        int unsigned tail, prv;
        tail = scb_pkg::TAIL_BASE
               + ((row * grid_span(grid_across) + col) % scb_pkg::MAX_CELLS);
        prv = prv_link[tail];
        nxt_link[prv] = LW'(id);
        prv_link[id] = LW'(prv);
        nxt_link[id] = LW'(tail);
        prv_link[tail] = LW'(id);
    endfunction

    function automatic void link_out(input int unsigned id);
        int unsigned a, b;
        a = prv_link[id];
        b = nxt_link[id];
        nxt_link[a] = LW'(b);
        prv_link[b] = LW'(a);
    endfunction

    function automatic void push_cell(input int unsigned col, input int unsigned row,
                                      input logic fin);
        scb_pkg::t_result r;
        r = '0;
        r.cell_col = BW'(col);
        r.cell_row = BW'(row);
        r.last = fin;
        add_due(r);
    endfunction

    // expected beats for one accepted item, state updated as the block does
    function automatic void bin_and_link(input scb_pkg::t_item it);
        int unsigned nx, ny, col, row, id;
        logic [CW-1:0] code;
        scb_pkg::t_result r;
        nx = grid_span(grid_across);
        ny = grid_span(grid_down);
        col = cell_bin(it.pos_x, size_w, nx);
        row = cell_bin(it.pos_y, size_h, ny);
        code = CW'((row << 5) | col);
        id = it.agent_id;
        r = '0;
        r.last = 1'b1;
        r.status = 1'b1;
        case (it.opcode)
            scb_pkg::OP_ADD: if (!agent_live[id]) begin
                agent_live[id] = 1'b1;
                agent_cell[id] = code;
                link_in(id, col, row);
                r.status = 1'b0;
                r.cell_col = BW'(col);
                r.cell_row = BW'(row);
            end
            scb_pkg::OP_UPDATE: if (agent_live[id]) begin
                if (agent_cell[id] != code) begin
                    link_out(id);
                    link_in(id, col, row);
                    agent_cell[id] = code;
                end
                r.status = 1'b0;
                r.cell_col = BW'(col);
                r.cell_row = BW'(row);
            end
            scb_pkg::OP_DELETE: if (agent_live[id]) begin
                agent_live[id] = 1'b0;
                link_out(id);
                r.status = 1'b0;
                r.cell_col = agent_cell[id][4:0];
                r.cell_row = agent_cell[id][9:5];
            end
            scb_pkg::OP_READ: if (it.link_index < scb_pkg::LINK_DEPTH) begin
                r.status = 1'b0;
                r.link_value = nxt_link[it.link_index];
            end
            scb_pkg::OP_QUERY: begin
                push_cell(col, row, ny <= 3 && nx <= 3);
                if (ny > 3) begin
                    push_cell(col, (row + 1) % ny, 1'b0);
                    push_cell(col, (row + ny - 1) % ny, nx <= 3);
                end
                if (nx > 3) begin
                    push_cell((col + 1) % nx, row, 1'b0);
                    push_cell((col + nx - 1) % nx, row, 1'b1);
                end
                return;
            end
            default: ;
        endcase
        add_due(r);
    endfunction

    // accept, predict and check at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                bin_and_link(i_item);
                took <= 1'b1;
            end else begin
                took <= 1'b0;
            end
            if (o_strobe) begin
                if (due_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected beat %p", o_result);
                end else if (due_results[0] !== o_result) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %p got %p", due_results[0], o_result);
                    void'(due_results.pop_front());
                end else begin
                    void'(due_results.pop_front());
                end
            end
        end
    end

    // sender: bursts of items with random gaps
    always @(negedge i_clk) begin
        int g, b;
        logic s;
        scb_pkg::t_item nxt;
        g = gap_left;
        b = burst_left;
        s = 1'b0;
        nxt = i_item;
        if (i_rst_n) begin
            if (took) begin
                void'(pending_items.pop_front());
                b = b - 1;
                if (b <= 0) begin
                    b = $urandom_range(1, 12);
                    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            if (g > 0) begin
                g = g - 1;
            end else if (pending_items.size() > 0) begin
                s = 1'b1;
                nxt = pending_items[0];
            end
        end
        gap_left <= g;
        burst_left <= b;
        i_start <= s;
        i_item <= nxt;
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [PW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            scb_pkg::CFG_ACROSS: grid_across = val[DW-1:0];
            scb_pkg::CFG_DOWN:   grid_down = val[DW-1:0];
            scb_pkg::CFG_WIDTH:  size_w = val;
            scb_pkg::CFG_HEIGHT: size_h = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input logic [PW-1:0] ac, input logic [PW-1:0] dn,
                            input logic [PW-1:0] w, input logic [PW-1:0] h);
        write_reg(scb_pkg::CFG_ACROSS, ac);
        write_reg(scb_pkg::CFG_DOWN, dn);
        write_reg(scb_pkg::CFG_WIDTH, w);
        write_reg(scb_pkg::CFG_HEIGHT, h);
    endtask

    // wait until every queued item is taken and every beat has come back
    task automatic drain();
        while (pending_items.size() > 0 || i_start || due_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [PW-1:0] pick_pos(input logic [PW-1:0] sz,
                                              input logic [DW-1:0] d);
        longint span;
        if ($urandom_range(0, 7) == 0) return PW'($urandom);
        span = longint'((sz == 0) ? 1 : sz) * grid_span(d);
        span = span + span / 4;
        if (span > 24'hFFFFFF) span = 24'hFFFFFF;
        return PW'($urandom_range(0, int'(span)));
    endfunction

    function automatic scb_pkg::t_item pick_item();
        scb_pkg::t_item it;
        int unsigned k;
        it = '0;
        k = $urandom_range(0, 99);
        if (k < 30) it.opcode = scb_pkg::OP_ADD;
        else if (k < 55) it.opcode = scb_pkg::OP_UPDATE;
        else if (k < 70) it.opcode = scb_pkg::OP_DELETE;
        else if (k < 84) it.opcode = scb_pkg::OP_READ;
        else if (k < 96) it.opcode = scb_pkg::OP_QUERY;
        else it.opcode = 3'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
        it.agent_id = ($urandom_range(0, 4) == 0) ? scb_pkg::AGENT_W'($urandom) :
                      scb_pkg::AGENT_W'($urandom_range(0, 23));
        it.pos_x = pick_pos(size_w, grid_across);
        it.pos_y = pick_pos(size_h, grid_down);
        k = $urandom_range(0, 9);
        if (k < 4) it.link_index = LW'($urandom_range(0, 23));
        else if (k < 8) it.link_index = LW'(scb_pkg::HEAD_BASE + $urandom_range(0, 40));
        else if (k < 9) it.link_index = LW'(scb_pkg::TAIL_BASE + $urandom_range(0, 40));
        else it.link_index = LW'($urandom);
        return it;
    endfunction

    function automatic scb_pkg::t_item make_item(input logic [2:0] op, input int unsigned id,
                                                 input logic [PW-1:0] px,
                                                 input logic [PW-1:0] py,
                                                 input int unsigned li);
        scb_pkg::t_item it;
        it.opcode = op;
        it.agent_id = scb_pkg::AGENT_W'(id);
        it.pos_x = px;
        it.pos_y = py;
        it.link_index = LW'(li);
        return it;
    endfunction

    task automatic random_phase(input int n);
        repeat (n) queue_item(pick_item());
        drain();
    endtask

    initial begin
        for (int i = 0; i < scb_pkg::LINK_DEPTH; i++) begin
            nxt_link[i] = '0;
            prv_link[i] = '0;
        end
        for (int c = 0; c < scb_pkg::MAX_CELLS; c++) begin
            nxt_link[scb_pkg::HEAD_BASE + c] = LW'(scb_pkg::TAIL_BASE + c);
            prv_link[scb_pkg::TAIL_BASE + c] = LW'(scb_pkg::HEAD_BASE + c);
        end
        for (int a = 0; a < scb_pkg::MAX_AGENTS; a++) begin
            agent_live[a] = 1'b0;
            agent_cell[a] = '0;
        end
        grid_across = 1;
        grid_down = 1;
        size_w = 256;
        size_h = 256;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = scb_pkg::CFG_ACROSS;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on a 32 x 32 grid of cells 256 wide and 256 high
        set_grid(32, 32, 256, 256);
        queue_item(make_item(scb_pkg::OP_ADD, 0, 0, 0, 0));
        queue_item(make_item(scb_pkg::OP_ADD, 0, 0, 0, 0));
        queue_item(make_item(scb_pkg::OP_ADD, 1023, 24'hFFFFFF, 24'hFFFFFF, 0));
        queue_item(make_item(scb_pkg::OP_ADD, 5, 24'h000100, 24'h000200, 0));
        queue_item(make_item(scb_pkg::OP_UPDATE, 7, 0, 0, 0));
        queue_item(make_item(scb_pkg::OP_DELETE, 7, 0, 0, 0));
        queue_item(make_item(scb_pkg::OP_UPDATE, 5, 24'h0001FF, 24'h0002FF, 0));
        queue_item(make_item(scb_pkg::OP_UPDATE, 5, 24'h000300, 24'h000000, 0));
        queue_item(make_item(scb_pkg::OP_READ, 0, 0, 0, 0));
        queue_item(make_item(scb_pkg::OP_READ, 0, 0, 0, scb_pkg::HEAD_BASE));
        queue_item(make_item(scb_pkg::OP_READ, 0, 0, 0, scb_pkg::LINK_DEPTH - 1));
        queue_item(make_item(scb_pkg::OP_READ, 0, 0, 0, scb_pkg::LINK_DEPTH));
        queue_item(make_item(scb_pkg::OP_READ, 0, 0, 0, 4095));
        queue_item(make_item(scb_pkg::OP_QUERY, 0, 0, 0, 0));
        queue_item(make_item(scb_pkg::OP_QUERY, 0, 24'hFFFFFF, 24'hFFFFFF, 0));
        queue_item(make_item(scb_pkg::OP_DELETE, 1023, 0, 0, 0));
        queue_item(make_item(scb_pkg::OP_DELETE, 5, 0, 0, 0));
        queue_item(make_item(OP_FIRST_SPARE, 3, 0, 0, 0));
        queue_item(make_item(3'd6, 3, 0, 0, 0));
        queue_item(make_item(OP_LAST_SPARE, 1023, 24'hFFFFFF, 24'hFFFFFF, 4095));
        drain();

        // zero and out of range sizes, a 1 x 32 grid with up and down neighbours
        set_grid(0, 63, 0, 0);
        queue_item(make_item(scb_pkg::OP_QUERY, 0, 5, 40, 0));
        queue_item(make_item(scb_pkg::OP_ADD, 9, 24'h800000, 24'h7FFFFF, 0));
        random_phase(60);

        set_grid(3, 4, 24'hFFFFFF, 24'h000001);
        random_phase(70);
        set_grid(4, 3, 24'h000040, 24'h0000C0);
        random_phase(70);
        set_grid(32, 32, 24'h000001, 24'hFFFFFF);
        random_phase(60);
        set_grid(1, 1, 256, 256);
        random_phase(40);
        set_grid($urandom_range(5, 31), $urandom_range(5, 31),
                 $urandom_range(1, 4096), $urandom_range(1, 4096));
        random_phase(110);

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/scb_pkg.sv
sv/scb_bin_div.sv
sv/spatial_cell_list_binning.sv
verif/spatial_cell_list_binning_tb.sv
